### hdl/vfc_pkg.sv
// types and constants shared by the voxel face cull store
package vfc_pkg;

  localparam int LABEL_W = 16;
  localparam int COORD_W = 4;
  localparam int SIZE_W  = 5;
  localparam int ACT_W   = 13;
  localparam int ACT_MAX = 8191;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_VIS   = 2'd1,
    OP_QUERY = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_UPD,
    ST_Q,
    ST_VIS,
    ST_VIS_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [LABEL_W-1:0] label;
    logic               show;
    logic               inchunk;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic deq;
    logic hold;
  } q_ctrl_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               vis;
  } cell_t;

endpackage

### hdl/voxel_face_cull_store_top.sv
// top level of the voxel face cull store: configuration registers and front/back ends
// after reset a clearing pass writes every cell, CHUNK_EDGE rounded up to a power of two, cubed;
// no transaction is accepted until it ends, configuration is always taken
// a query makes seven store reads: the voxel and its six neighbours
// visibility walks used_x*used_y*used_z voxels, one voxel per cycle; skipped with no active voxel
// a two-entry queue and the result register let input and output stall on their own
module voxel_face_cull_store_top #(
  parameter int CHUNK_EDGE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  vox_x,
  input  logic [3:0]  vox_y,
  input  logic [3:0]  vox_z,
  input  logic signed [15:0] label_in,
  input  logic        show,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  face_mask,
  output logic signed [15:0] label_out,
  output logic        visible,
  output logic [12:0] active_count,
  output logic        dirty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import vfc_pkg::*;

  cfg_t    cfg;
  q_head_t head;
  q_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= 5'd16;
      cfg.size_y <= 5'd16;
      cfg.size_z <= 5'd16;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SIZE_X: cfg.size_x <= cfg_data;
        REG_SIZE_Y: cfg.size_y <= cfg_data;
        REG_SIZE_Z: cfg.size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  vfc_front #(.CHUNK_EDGE(CHUNK_EDGE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .vox_x    (vox_x),
    .vox_y    (vox_y),
    .vox_z    (vox_z),
    .label_in (label_in),
    .show     (show),
    .ctrl     (ctrl),
    .head     (head)
  );

  vfc_back #(.CHUNK_EDGE(CHUNK_EDGE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .ctrl         (ctrl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .face_mask    (face_mask),
    .label_out    (label_out),
    .visible      (visible),
    .active_count (active_count),
    .dirty        (dirty)
  );

endmodule

### hdl/vfc_front.sv
// front end: classifies incoming transactions and queues them for the back end
module vfc_front #(
  parameter int CHUNK_EDGE = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [vfc_pkg::COORD_W-1:0] vox_x,
  input  logic [vfc_pkg::COORD_W-1:0] vox_y,
  input  logic [vfc_pkg::COORD_W-1:0] vox_z,
  input  logic signed [vfc_pkg::LABEL_W-1:0] label_in,
  input  logic                      show,
  input  vfc_pkg::q_ctrl_t          ctrl,
  output vfc_pkg::q_head_t          head
);
  import vfc_pkg::*;

  item_t       entries [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       cls;
  logic [6:0]  edge_lim;

  assign edge_lim = 7'(CHUNK_EDGE);

  always_comb begin
    cls.op      = op_t'(op);
    cls.x       = vox_x;
    cls.y       = vox_y;
    cls.z       = vox_z;
    cls.label   = label_in;
    cls.show    = show;
    cls.inchunk = (7'(vox_x) < edge_lim) && (7'(vox_y) < edge_lim) && (7'(vox_z) < edge_lim);
  end

  assign in_ready   = (count != 2'd2) && !ctrl.hold;
  assign push       = in_valid && in_ready;
  assign pop        = ctrl.deq && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/vfc_back.sv
// back end: voxel store, sequencer for the four operations and result register
module vfc_back #(
  parameter int CHUNK_EDGE = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vfc_pkg::cfg_t              cfg,
  input  vfc_pkg::q_head_t           head,
  output vfc_pkg::q_ctrl_t           ctrl,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [5:0]                 face_mask,
  output logic signed [vfc_pkg::LABEL_W-1:0] label_out,
  output logic                       visible,
  output logic [vfc_pkg::ACT_W-1:0]  active_count,
  output logic                       dirty
);
  import vfc_pkg::*;

  localparam int CW    = $clog2(CHUNK_EDGE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int CNTW  = $clog2(CELLS + 1);

  state_t            state, state_next;
  item_t             cur;
  cell_t             mem [DEPTH];
  cell_t             rdata;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;
  cell_t             wdata;
  logic [AW-1:0]     clr_cnt;
  logic [2:0]        qcnt;
  logic [CW-1:0]     ci, cj, ck;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [LABEL_W-1:0] ctr_label;
  logic              ctr_vis;
  logic [5:0]        raw_mask;
  logic [5:0]        ok;
  logic [CNTW-1:0]   cnt;
  logic              chg;
  logic [6:0]        nx, ny, nz, x7, y7, z7, edge7;
  logic              in_used;
  logic              ci_last, cj_last, ck_last;
  logic              go_out;
  logic              vis_hit;
  logic [AW-1:0]     cur_addr, walk_addr, q_addr;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] x, input logic [6:0] y,
                                              input logic [6:0] z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  assign edge7 = 7'(CHUNK_EDGE);
  assign nx = (7'(cfg.size_x) > edge7) ? edge7 : 7'(cfg.size_x);
  assign ny = (7'(cfg.size_y) > edge7) ? edge7 : 7'(cfg.size_y);
  assign nz = (7'(cfg.size_z) > edge7) ? edge7 : 7'(cfg.size_z);
  assign x7 = 7'(cur.x);
  assign y7 = 7'(cur.y);
  assign z7 = 7'(cur.z);
  assign in_used = (x7 < nx) && (y7 < ny) && (z7 < nz);

  assign ok[0] = (z7 + 7'd1) < nz;
  assign ok[1] = z7 != 7'd0;
  assign ok[2] = (x7 + 7'd1) < nx;
  assign ok[3] = x7 != 7'd0;
  assign ok[4] = (y7 + 7'd1) < ny;
  assign ok[5] = y7 != 7'd0;

  assign ci_last = (7'(ci) + 7'd1) == nx;
  assign cj_last = (7'(cj) + 7'd1) == ny;
  assign ck_last = (7'(ck) + 7'd1) == nz;

  assign cur_addr  = cell_addr(x7, y7, z7);
  assign walk_addr = cell_addr(7'(ci), 7'(cj), 7'(ck));
  assign vis_hit   = pend && (rdata.label == cur.label);
  assign go_out    = !out_valid || out_ready;

  always_comb begin
    case (qcnt)
      3'd1:    q_addr = cell_addr(x7, y7, z7 + 7'd1);
      3'd2:    q_addr = cell_addr(x7, y7, z7 - 7'd1);
      3'd3:    q_addr = cell_addr(x7 + 7'd1, y7, z7);
      3'd4:    q_addr = cell_addr(x7 - 7'd1, y7, z7);
      3'd5:    q_addr = cell_addr(x7, y7 + 7'd1, z7);
      3'd6:    q_addr = cell_addr(x7, y7 - 7'd1, z7);
      default: q_addr = cur_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    waddr      = cur_addr;
    wdata      = '0;
    raddr      = cur_addr;
    ctrl.deq   = 1'b0;
    ctrl.hold  = (state == ST_CLEAR);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_cnt;
        if (clr_cnt == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          ctrl.deq = 1'b1;
          case (head.item.op)
            OP_WRITE: state_next = head.item.inchunk ? ST_WR_RD : ST_DONE;
            OP_QUERY: state_next = head.item.inchunk ? ST_Q : ST_DONE;
            OP_VIS: begin
              if (cnt != '0 && nx != 7'd0 && ny != 7'd0 && nz != 7'd0) begin
                state_next = ST_VIS;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_WR_RD: state_next = ST_WR_UPD;
      ST_WR_UPD: begin
        if (rdata.label != cur.label) begin
          mem_we      = 1'b1;
          wdata.label = cur.label;
          wdata.vis   = |cur.label;
        end
        state_next = ST_DONE;
      end
      ST_Q: begin
        raddr = q_addr;
        if (qcnt == 3'd7) state_next = ST_DONE;
      end
      ST_VIS: begin
        raddr       = walk_addr;
        mem_we      = vis_hit;
        waddr       = pend_addr;
        wdata.label = cur.label;
        wdata.vis   = cur.show;
        if (ci_last && cj_last && ck_last) state_next = ST_VIS_END;
      end
      ST_VIS_END: begin
        mem_we      = vis_hit;
        waddr       = pend_addr;
        wdata.label = cur.label;
        wdata.vis   = cur.show;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (go_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      cnt       <= '0;
      chg       <= 1'b0;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && go_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          if (head.valid) begin
            cur       <= head.item;
            qcnt      <= 3'd0;
            ci        <= '0;
            cj        <= '0;
            ck        <= '0;
            pend      <= 1'b0;
            raw_mask  <= '0;
            ctr_label <= '0;
            ctr_vis   <= 1'b0;
            if (head.item.op == OP_ACK) chg <= 1'b0;
          end
        end
        ST_WR_UPD: begin
          if (rdata.label != cur.label) begin
            chg <= 1'b1;
            if (rdata.label == '0) cnt <= cnt + 1'b1;
            else if (cur.label == '0) cnt <= cnt - 1'b1;
          end
        end
        ST_Q: begin
          qcnt <= qcnt + 3'd1;
          if (qcnt == 3'd1) begin
            ctr_label <= rdata.label;
            ctr_vis   <= rdata.vis;
          end else if (qcnt != 3'd0) begin
            raw_mask[qcnt - 3'd2] <= !(ok[qcnt - 3'd2] && (rdata.label == ctr_label));
          end
        end
        ST_VIS, ST_VIS_END: begin
          if (vis_hit) chg <= 1'b1;
          pend      <= 1'b1;
          pend_addr <= walk_addr;
          if (ci_last) begin
            ci <= '0;
            if (cj_last) begin
              cj <= '0;
              ck <= ck + 1'b1;
            end else begin
              cj <= cj + 1'b1;
            end
          end else begin
            ci <= ci + 1'b1;
          end
        end
        ST_DONE: begin
          if (go_out) begin
            face_mask    <= (ctr_vis && in_used) ? raw_mask : 6'd0;
            label_out    <= ctr_label;
            visible      <= ctr_vis;
            active_count <= (32'(cnt) > 32'(ACT_MAX)) ? ACT_W'(ACT_MAX) : ACT_W'(cnt);
            dirty        <= chg;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 32'(CELLS)) else $error("active count above chunk size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE || state == ST_Q) |-> !mem_we)
    else $error("store written outside an update state");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !ctrl.deq))
    else $error("activity during clearing pass");

endmodule
